@@ rtl/core/sjf_pkg.sv @@
// Shared constants and control/status types for the shortest-job-first scheduler.
// No dependencies; imported by every module of the block.
package sjf_pkg;

    localparam int MAX_JOBS = 64;
    localparam int TIME_W   = 16;
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int ID_W     = 7;
    localparam int T_W      = 23;
    localparam int IN_W     = 2 * TIME_W;
    localparam int OUT_RAW  = ID_W + 3 * T_W;
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic time_jump;
        logic emit;
        logic close_set;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic found;
        logic last_pick;
        logic out_free;
    } dp_stat_t;

endpackage

@@ rtl/core/shortest_job_first_scheduler.sv @@
// Non-preemptive shortest-job-first scheduler: jobs stream in one request per cycle, and
// the request carrying tlast closes the set and starts scheduling. While scheduling the
// block accepts no request. Each pick scans the job store through its single read port,
// one job per cycle, and scans once more whenever no job has arrived yet and time jumps
// to the earliest pending arrival. Results leave through an output register; the next
// scan runs while a result waits, and a pick holds only if that register is still full.
// Jobs beyond 64 are dropped.
// Top level; depends on sjf_pkg, sjf_ctrl and sjf_datapath.
module shortest_job_first_scheduler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sjf_pkg::IN_W-1:0]    s_tdata,   // arrival_time, burst_time
    input  logic                        s_tlast,   // last_item
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sjf_pkg::OUT_W-1:0]   m_tdata,   // job_id, completion_time,
                                                   // turnaround_time, waiting_time, zero pad
    output logic                        m_tlast    // last_result
);
    import sjf_pkg::*;

    ctrl_cmd_t         cmd;
    dp_stat_t          stat;
    logic [ID_W-1:0]   job_id;
    logic [T_W-1:0]    completion;
    logic [T_W-1:0]    turnaround;
    logic [T_W-1:0]    waiting;

    sjf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sjf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_arrival     (s_tdata[TIME_W-1:0]),
        .in_burst       (s_tdata[IN_W-1:TIME_W]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_job_id     (job_id),
        .out_completion (completion),
        .out_turnaround (turnaround),
        .out_waiting    (waiting),
        .out_last       (m_tlast)
    );

    assign m_tdata = {{(OUT_W - OUT_RAW){1'b0}}, waiting, turnaround, completion, job_id};

    a_wait_le_turn: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (waiting <= turnaround))
        else $error("waiting time exceeds turnaround time");

    a_turn_le_comp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (turnaround <= completion))
        else $error("turnaround time exceeds completion time");

    a_close_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close_set |=> (m_tvalid && m_tlast && s_tready))
        else $error("set closed without a marked final result");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !cmd.emit)
        else $error("result register overwritten while full");

endmodule

@@ rtl/core/sjf_ctrl.sv @@
// Controller state machine: loads the job set, sequences store scans and picks.
// Depends on sjf_pkg; drives sjf_datapath through ctrl_cmd_t.
module sjf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  sjf_pkg::dp_stat_t stat,
    output sjf_pkg::ctrl_cmd_t cmd
);
    import sjf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.found)
                begin
                    cmd.time_jump  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_pick)
                    begin
                        cmd.close_set = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/sjf_datapath.sv @@
// Datapath: job stores, done flags, scan pipeline, time keeping and result register.
// Depends on sjf_pkg; commanded by sjf_ctrl.
module sjf_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sjf_pkg::ctrl_cmd_t          cmd,
    output sjf_pkg::dp_stat_t           stat,
    input  logic [sjf_pkg::TIME_W-1:0]  in_arrival,
    input  logic [sjf_pkg::TIME_W-1:0]  in_burst,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [sjf_pkg::ID_W-1:0]    out_job_id,
    output logic [sjf_pkg::T_W-1:0]     out_completion,
    output logic [sjf_pkg::T_W-1:0]     out_turnaround,
    output logic [sjf_pkg::T_W-1:0]     out_waiting,
    output logic                        out_last
);
    import sjf_pkg::*;

    logic [TIME_W-1:0]   arr_mem [MAX_JOBS];
    logic [TIME_W-1:0]   bur_mem [MAX_JOBS];
    logic [MAX_JOBS-1:0] done_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    finished_reg;
    logic [T_W-1:0]      cur_reg;
    logic [CNT_W-1:0]    idx_reg;

    logic [TIME_W-1:0]   arr_rd_reg;
    logic [TIME_W-1:0]   bur_rd_reg;
    logic                cmp_valid_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;

    logic                found_reg;
    logic                any_reg;
    logic [TIME_W-1:0]   best_bur_reg;
    logic [TIME_W-1:0]   best_arr_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [TIME_W-1:0]   earliest_reg;

    logic                out_valid_reg;

    logic                issue;
    logic                pending;
    logic                eligible;
    logic                take_best;
    logic                take_early;
    logic [T_W-1:0]      comp;
    logic [T_W-1:0]      wait_t;
    logic [T_W-1:0]      turn;

    assign stat.scan_end  = (idx_reg == count_reg);
    assign stat.found     = found_reg;
    assign stat.last_pick = ((finished_reg + CNT_W'(1)) == count_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign issue      = cmd.scan_step && (idx_reg != count_reg);
    assign pending    = cmp_valid_reg && !done_reg[cmp_idx_reg];
    assign eligible   = pending && (T_W'(arr_rd_reg) <= cur_reg);
    assign take_best  = eligible && (!found_reg || (bur_rd_reg < best_bur_reg));
    assign take_early = pending && (!any_reg || (arr_rd_reg < earliest_reg));

    assign comp   = cur_reg + T_W'(best_bur_reg);
    assign wait_t = cur_reg - T_W'(best_arr_reg);
    assign turn   = wait_t + T_W'(best_bur_reg);

    // job stores, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg != CNT_W'(MAX_JOBS)))
        begin
            arr_mem[count_reg[IDX_W-1:0]] <= in_arrival;
            bur_mem[count_reg[IDX_W-1:0]] <= in_burst;
        end
        arr_rd_reg <= arr_mem[idx_reg[IDX_W-1:0]];
        bur_rd_reg <= bur_mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            count_reg     <= '0;
            finished_reg  <= '0;
            cur_reg       <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && (count_reg != CNT_W'(MAX_JOBS)))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            cmp_valid_reg <= issue;
            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                any_reg   <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (take_best)
                begin
                    found_reg <= 1'b1;
                end
                if (pending)
                begin
                    any_reg <= 1'b1;
                end
            end

            if (cmd.time_jump)
            begin
                cur_reg <= T_W'(earliest_reg);
            end

            if (cmd.close_set)
            begin
                done_reg     <= '0;
                count_reg    <= '0;
                finished_reg <= '0;
                cur_reg      <= '0;
            end
            else if (cmd.emit)
            begin
                done_reg[best_idx_reg] <= 1'b1;
                finished_reg           <= finished_reg + CNT_W'(1);
                cur_reg                <= comp;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan accumulators and result payload
    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_bur_reg <= bur_rd_reg;
            best_arr_reg <= arr_rd_reg;
            best_idx_reg <= cmp_idx_reg;
        end
        if (take_early)
        begin
            earliest_reg <= arr_rd_reg;
        end
        cmp_idx_reg <= idx_reg[IDX_W-1:0];
        if (cmd.emit)
        begin
            out_job_id     <= ID_W'(best_idx_reg) + ID_W'(1);
            out_completion <= comp;
            out_turnaround <= turn;
            out_waiting    <= wait_t;
            out_last       <= stat.last_pick;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ bench/sched_tb_pkg.sv @@
// Schedule predictor and result scoreboard for the shortest-job-first scheduler bench.
// Depends on sjf_pkg for store depth and field widths; used by tb_top.
package sched_tb_pkg;

    import sjf_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0] job_id;
        logic [T_W-1:0]  completion_time;
        logic [T_W-1:0]  turnaround_time;
        logic [T_W-1:0]  waiting_time;
        logic            last_result;
    } sched_result_t;

    class sjf_scoreboard;
        logic [TIME_W-1:0] arrival_mem [MAX_JOBS];
        logic [TIME_W-1:0] burst_mem [MAX_JOBS];
        bit                done_mem [MAX_JOBS];
        int unsigned       stored_jobs;
        sched_result_t     schedule_q [$];
        int unsigned       mismatches;
        int unsigned       results_seen;
        int unsigned       requests_seen;
        int unsigned       sets_closed;
        int unsigned       dropped_jobs;

        function new();
            stored_jobs   = 0;
            mismatches    = 0;
            results_seen  = 0;
            requests_seen = 0;
            sets_closed   = 0;
            dropped_jobs  = 0;
            foreach (done_mem[i])
                done_mem[i] = 1'b0;
        endfunction

        // Store one job request; on the closing request, predict the whole schedule.
        function void note_request(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur,
                                   logic last);
            int unsigned       finished;
            int unsigned       pick;
            int unsigned       i;
            bit                found;
            bit                any_pending;
            longint unsigned   now_t;
            longint unsigned   best;
            longint unsigned   earliest;
            longint unsigned   comp;
            sched_result_t     res;
            requests_seen++;
            if (stored_jobs < MAX_JOBS) begin
                arrival_mem[stored_jobs] = arr;
                burst_mem[stored_jobs]   = bur;
                done_mem[stored_jobs]    = 1'b0;
                stored_jobs++;
            end
            else
                dropped_jobs++;
            if (!last)
                return;
            sets_closed++;
            now_t    = 0;
            finished = 0;
            while (finished < stored_jobs) begin
                found       = 1'b0;
                any_pending = 1'b0;
                best        = 0;
                earliest    = 0;
                pick        = 0;
                for (i = 0; i < stored_jobs; i++) begin
                    if (done_mem[i])
                        continue;
                    if (!any_pending || arrival_mem[i] < earliest)
                        earliest = arrival_mem[i];
                    any_pending = 1'b1;
                    if (arrival_mem[i] <= now_t && (!found || burst_mem[i] < best)) begin
                        found = 1'b1;
                        best  = burst_mem[i];
                        pick  = i;
                    end
                end
                if (!found) begin
                    now_t = earliest;
                    continue;
                end
                comp           = now_t + burst_mem[pick];
                done_mem[pick] = 1'b1;
                finished++;
                now_t               = comp;
                res.job_id          = ID_W'(pick + 1);
                res.completion_time = T_W'(comp);
                res.turnaround_time = T_W'(comp - arrival_mem[pick]);
                res.waiting_time    = T_W'(comp - arrival_mem[pick] - burst_mem[pick]);
                res.last_result     = (finished == stored_jobs);
                schedule_q.push_back(res);
            end
            foreach (done_mem[j])
                done_mem[j] = 1'b0;
            stored_jobs = 0;
        endfunction

        // Compare one accepted result with the oldest predicted pick.
        function void check_result(logic [OUT_W-1:0] data, logic last);
            sched_result_t got;
            sched_result_t want;
            got.job_id          = data[ID_W-1:0];
            got.completion_time = data[ID_W +: T_W];
            got.turnaround_time = data[ID_W + T_W +: T_W];
            got.waiting_time    = data[ID_W + 2 * T_W +: T_W];
            got.last_result     = last;
            results_seen++;
            if (schedule_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: id=%0d comp=%0d turn=%0d wait=%0d last=%0b",
                             got.job_id, got.completion_time, got.turnaround_time,
                             got.waiting_time, got.last_result);
                mismatches++;
                return;
            end
            want = schedule_q.pop_front();
            if (got.job_id != want.job_id || got.completion_time != want.completion_time ||
                got.turnaround_time != want.turnaround_time ||
                got.waiting_time != want.waiting_time || got.last_result != want.last_result)
            begin
                if (mismatches < 10) begin
                    $display("mismatch: expected id=%0d comp=%0d turn=%0d wait=%0d last=%0b",
                             want.job_id, want.completion_time, want.turnaround_time,
                             want.waiting_time, want.last_result);
                    $display("          actual   id=%0d comp=%0d turn=%0d wait=%0d last=%0b",
                             got.job_id, got.completion_time, got.turnaround_time,
                             got.waiting_time, got.last_result);
                end
                mismatches++;
            end
        endfunction
    endclass

endpackage

@@ bench/tb_top.sv @@
// Top-level bench for shortest_job_first_scheduler: directed and random job sets with
// bursty requests and a stalling result sink. Depends on sjf_pkg and sched_tb_pkg.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sjf_pkg::*;
    import sched_tb_pkg::*;

    localparam int IDLE_LIMIT     = 4000;
    localparam int RANDOM_ITEMS   = 480;
    localparam int DRAIN_CYCLES   = 200;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tlast;

    sjf_scoreboard       sb;
    int                  burst_left = 0;
    int                  idle_cycles = 0;
    int                  rx_left = 0;
    logic                rx_state = 1'b0;

    shortest_job_first_scheduler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Stall the result sink in random stretches.
    always @(negedge clk)
    begin
        if (rx_left == 0) begin
            rx_state = ($urandom_range(0, 3) != 0);
            rx_left  = rx_state ? $urandom_range(1, 30) : $urandom_range(1, 12);
        end
        rx_left--;
        m_tready <= rx_state;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata[TIME_W-1:0], s_tdata[TIME_W +: TIME_W], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Issue one job request; call at a falling edge, returns at a falling edge.
    task automatic send_request(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] bur,
                                input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 48 : 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {bur, arr};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_time(int mode);
        case (mode)
            0:       return '0;
            1:       return TIME_W'($urandom_range(0, 15));
            2:       return TIME_W'($urandom_range(0, 63));
            3:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: return TIME_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int set_no;
        int set_size;
        int sent;
        int amode;
        int bmode;
        int k;
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(16'd0, 16'd0, 1'b1);
        send_request(16'hFFFF, 16'hFFFF, 1'b1);
        send_request(16'd0, 16'd5, 1'b0);
        send_request(16'd0, 16'd5, 1'b0);
        send_request(16'd0, 16'd3, 1'b0);
        send_request(16'd0, 16'd5, 1'b1);
        send_request(16'd10, 16'd4, 1'b0);
        send_request(16'd2, 16'd9, 1'b0);
        send_request(16'd40, 16'd1, 1'b0);
        send_request(16'd3, 16'd2, 1'b1);
        send_request(16'd5, 16'd0, 1'b0);
        send_request(16'd5, 16'd0, 1'b0);
        send_request(16'd0, 16'hFFFF, 1'b1);
        send_request(16'hFFFF, 16'hFFFF, 1'b0);
        send_request(16'hFFFF, 16'd0, 1'b1);
        send_request(16'd0, 16'd7, 1'b0);
        send_request(16'd0, 16'd6, 1'b0);
        send_request(16'd0, 16'd5, 1'b0);
        send_request(16'd0, 16'd4, 1'b0);
        send_request(16'd0, 16'd1, 1'b1);

        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if (set_no == 1)
                set_size = MAX_JOBS + 4;
            else if ($urandom_range(0, 11) == 0)
                set_size = $urandom_range(MAX_JOBS - 4, MAX_JOBS + 8);
            else
                set_size = $urandom_range(1, 10);
            amode = $urandom_range(0, 4);
            bmode = $urandom_range(1, 4);
            for (k = 0; k < set_size; k++)
                send_request(pick_time(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : amode),
                             pick_time(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : bmode),
                             k == set_size - 1);
            sent += set_size;
            set_no++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.schedule_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d job sets from %0d requests, %0d jobs dropped past a full store",
                 sb.sets_closed, sb.requests_seen, sb.dropped_jobs);
        $display("%0d scheduled results checked, %0d mismatches, %0d picks never seen",
                 sb.results_seen, sb.mismatches, sb.schedule_q.size());
        if (sb.mismatches == 0 && sb.schedule_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ shortest_job_first_scheduler.f @@
rtl/core/sjf_pkg.sv
rtl/core/sjf_ctrl.sv
rtl/core/sjf_datapath.sv
rtl/core/shortest_job_first_scheduler.sv
bench/sched_tb_pkg.sv
bench/tb_top.sv
